[rtl/at2_pkg.sv]
// ----------------------------------------------------------------------------
// at2_pkg
// Shared widths, constants, types and step functions of the atan2 pipeline.
// ----------------------------------------------------------------------------
package at2_pkg;

    localparam int DATA_W             = 16;
    localparam int Q_W                = 16;
    localparam int DIV_BITS_PER_STAGE = 2;
    localparam int DIV_STAGES         = Q_W / DIV_BITS_PER_STAGE;
    localparam int POLY_STEPS         = 5;
    localparam int PROD_W             = DATA_W + Q_W + 1;
    localparam int SUM_W              = PROD_W + 1;
    // prep + divider + (multiply, add) per polynomial step + fold
    localparam int LATENCY            = 1 + DIV_STAGES + 2 * POLY_STEPS + 1;

    localparam logic [Q_W-1:0]    RATIO_ONE   = 16'h8000;
    localparam logic [DATA_W-1:0] ANG_EIGHTH  = 16'h2000;
    localparam logic [DATA_W-1:0] ANG_QUARTER = 16'h4000;
    localparam logic [DATA_W-1:0] ANG_HALF    = 16'h8000;

    // first step computes bias - q * 0x96, i.e. a seed of -0x96 times q
    localparam logic signed [DATA_W-1:0] POLY_SEED = -16'sh0096;

    typedef struct packed {
        logic zero;
        logic swapped;
        logic x_neg;
        logic y_neg;
    } at2_side_t;

    function automatic logic signed [SUM_W-1:0] poly_bias(input int step);
        logic signed [SUM_W-1:0] bias;
        case (step)
            0:       bias = 34'sd36790272;    // 0x118b << 13
            1:       bias = -34'sd281116672;  // -(0x4306 << 14)
            2:       bias = 34'sd3555328;     // 0x364 << 12
            3:       bias = 34'sd341721088;   // 0x5179 << 14
            default: bias = '0;
        endcase
        return bias;
    endfunction

    function automatic int poly_shift(input int step);
        int sh;
        case (step)
            0:       sh = 13;
            1:       sh = 16;
            default: sh = 15;
        endcase
        return sh;
    endfunction

    // one restoring division step: returns {quotient bit, new remainder}
    function automatic logic [DATA_W:0] div_step(
        input logic [DATA_W-1:0] rem,
        input logic              bit_in,
        input logic [DATA_W-1:0] divisor
    );
        logic [DATA_W:0] trial;
        logic [DATA_W:0] diff;
        trial = {rem, bit_in};
        diff  = trial - {1'b0, divisor};
        if (trial >= {1'b0, divisor})
        begin
            return {1'b1, diff[DATA_W-1:0]};
        end
        return {1'b0, trial[DATA_W-1:0]};
    endfunction

endpackage

[rtl/at2_prep.sv]
// ----------------------------------------------------------------------------
// at2_prep
// Input stage: magnitudes, ordering into min/max and quadrant flags.
// ----------------------------------------------------------------------------
module at2_prep
    import at2_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic signed [DATA_W-1:0] y_value,
    input  logic signed [DATA_W-1:0] x_value,
    output logic                     out_valid,
    output logic [DATA_W-1:0]        min_mag,
    output logic [DATA_W-1:0]        max_mag,
    output at2_side_t                side
);

    logic              valid_reg;
    logic [DATA_W-1:0] min_reg, min_next;
    logic [DATA_W-1:0] max_reg, max_next;
    at2_side_t         side_reg, side_next;
    logic [DATA_W-1:0] mag_y, mag_x;

    always_comb
    begin
        // -32768 maps to 0x8000, which fits unsigned
        mag_y = y_value[DATA_W-1] ? (~y_value + 16'd1) : y_value;
        mag_x = x_value[DATA_W-1] ? (~x_value + 16'd1) : x_value;
        side_next.swapped = mag_y > mag_x;
        side_next.x_neg   = x_value[DATA_W-1];
        side_next.y_neg   = y_value[DATA_W-1];
        if (side_next.swapped)
        begin
            min_next = mag_x;
            max_next = mag_y;
        end
        else
        begin
            min_next = mag_y;
            max_next = mag_x;
        end
        side_next.zero = (max_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        min_reg  <= min_next;
        max_reg  <= max_next;
        side_reg <= side_next;
    end

    assign out_valid = valid_reg;
    assign min_mag   = min_reg;
    assign max_mag   = max_reg;
    assign side      = side_reg;

endmodule

[rtl/at2_div.sv]
// ----------------------------------------------------------------------------
// at2_div
// Pipelined restoring divider: q = (min << 15) / max, two bits per stage.
// ----------------------------------------------------------------------------
module at2_div
    import at2_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [DATA_W-1:0] min_mag,
    input  logic [DATA_W-1:0] max_mag,
    input  at2_side_t         in_side,
    output logic              out_valid,
    output logic [Q_W-1:0]    q,
    output at2_side_t         out_side
);

    logic              st_valid_reg [DIV_STAGES];
    logic [DATA_W-1:0] st_rem_reg   [DIV_STAGES];
    logic [Q_W-1:0]    st_q_reg     [DIV_STAGES];
    logic [DATA_W-1:0] st_dvs_reg   [DIV_STAGES];
    at2_side_t         st_side_reg  [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_stage
        logic              src_valid;
        logic [DATA_W-1:0] src_rem;
        logic [Q_W-1:0]    src_q;
        logic [DATA_W-1:0] src_dvs;
        at2_side_t         src_side;
        logic              src_lsb;
        logic [DATA_W-1:0] rem_next;
        logic [Q_W-1:0]    q_next;

        if (s == 0)
        begin : g_first
            // start from min >> 1 and shift its lsb in on the first step
            assign src_valid = in_valid;
            assign src_rem   = {1'b0, min_mag[DATA_W-1:1]};
            assign src_q     = '0;
            assign src_dvs   = max_mag;
            assign src_side  = in_side;
            assign src_lsb   = min_mag[0];
        end
        else
        begin : g_rest
            assign src_valid = st_valid_reg[s-1];
            assign src_rem   = st_rem_reg[s-1];
            assign src_q     = st_q_reg[s-1];
            assign src_dvs   = st_dvs_reg[s-1];
            assign src_side  = st_side_reg[s-1];
            assign src_lsb   = 1'b0;
        end

        always_comb
        begin
            logic [DATA_W:0] res;
            logic            bit_in;
            rem_next = src_rem;
            q_next   = src_q;
            for (int b = 0; b < DIV_BITS_PER_STAGE; b++)
            begin
                bit_in   = (b == 0) ? src_lsb : 1'b0;
                res      = div_step(rem_next, bit_in, src_dvs);
                rem_next = res[DATA_W-1:0];
                q_next   = {q_next[Q_W-2:0], res[DATA_W]};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                st_valid_reg[s] <= 1'b0;
            end
            else
            begin
                st_valid_reg[s] <= src_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            st_rem_reg[s]  <= rem_next;
            st_q_reg[s]    <= q_next;
            st_dvs_reg[s]  <= src_dvs;
            st_side_reg[s] <= src_side;
        end
    end

    assign out_valid = st_valid_reg[DIV_STAGES-1];
    assign q         = st_q_reg[DIV_STAGES-1];
    assign out_side  = st_side_reg[DIV_STAGES-1];

endmodule

[rtl/at2_poly.sv]
// ----------------------------------------------------------------------------
// at2_poly
// Nested polynomial in q: per step a registered p * q, then bias and shift.
// ----------------------------------------------------------------------------
module at2_poly
    import at2_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic [Q_W-1:0]           in_q,
    input  at2_side_t                in_side,
    output logic                     out_valid,
    output logic [Q_W-1:0]           out_q,
    output at2_side_t                out_side,
    output logic signed [DATA_W-1:0] octant
);

    logic                     mul_valid_reg [POLY_STEPS];
    logic [Q_W-1:0]           mul_q_reg     [POLY_STEPS];
    at2_side_t                mul_side_reg  [POLY_STEPS];
    logic signed [PROD_W-1:0] mul_prod_reg  [POLY_STEPS];

    logic                     add_valid_reg [POLY_STEPS];
    logic [Q_W-1:0]           add_q_reg     [POLY_STEPS];
    at2_side_t                add_side_reg  [POLY_STEPS];
    logic signed [DATA_W-1:0] add_p_reg     [POLY_STEPS];

    for (genvar k = 0; k < POLY_STEPS; k++)
    begin : g_step
        localparam int SHIFT = poly_shift(k);

        logic                     src_valid;
        logic [Q_W-1:0]           src_q;
        at2_side_t                src_side;
        logic signed [DATA_W-1:0] src_p;
        logic signed [PROD_W-1:0] prod_next;
        logic signed [SUM_W-1:0]  sum;
        logic signed [SUM_W-1:0]  shifted;
        logic signed [DATA_W-1:0] p_next;

        if (k == 0)
        begin : g_first
            assign src_valid = in_valid;
            assign src_q     = in_q;
            assign src_side  = in_side;
            assign src_p     = POLY_SEED;
        end
        else
        begin : g_rest
            assign src_valid = add_valid_reg[k-1];
            assign src_q     = add_q_reg[k-1];
            assign src_side  = add_side_reg[k-1];
            assign src_p     = add_p_reg[k-1];
        end

        assign prod_next = src_p * $signed({1'b0, src_q});
        assign sum       = poly_bias(k)
                           + $signed({mul_prod_reg[k][PROD_W-1], mul_prod_reg[k]});
        assign shifted   = sum >>> SHIFT;
        // every intermediate term stays within 16 signed bits
        assign p_next    = shifted[DATA_W-1:0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                mul_valid_reg[k] <= 1'b0;
                add_valid_reg[k] <= 1'b0;
            end
            else
            begin
                mul_valid_reg[k] <= src_valid;
                add_valid_reg[k] <= mul_valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            mul_q_reg[k]    <= src_q;
            mul_side_reg[k] <= src_side;
            mul_prod_reg[k] <= prod_next;
            add_q_reg[k]    <= mul_q_reg[k];
            add_side_reg[k] <= mul_side_reg[k];
            add_p_reg[k]    <= p_next;
        end
    end

    assign out_valid = add_valid_reg[POLY_STEPS-1];
    assign out_q     = add_q_reg[POLY_STEPS-1];
    assign out_side  = add_side_reg[POLY_STEPS-1];
    assign octant    = add_p_reg[POLY_STEPS-1];

endmodule

[rtl/at2_fold.sv]
// ----------------------------------------------------------------------------
// at2_fold
// Output stage: unit-ratio case, unswap and quadrant fold, result register.
// ----------------------------------------------------------------------------
module at2_fold
    import at2_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic [Q_W-1:0]           q,
    input  at2_side_t                side,
    input  logic signed [DATA_W-1:0] octant,
    output logic                     done,
    output logic signed [DATA_W-1:0] angle
);

    logic              done_reg;
    logic [DATA_W-1:0] angle_reg, angle_next;

    always_comb
    begin
        logic [DATA_W-1:0] r;
        r = (q == RATIO_ONE) ? ANG_EIGHTH : octant;
        if (side.swapped)
        begin
            r = ANG_QUARTER - r;
        end
        if (!side.x_neg)
        begin
            if (side.y_neg)
            begin
                r = '0 - r;
            end
        end
        else if (!side.y_neg)
        begin
            r = ANG_HALF - r;
        end
        else
        begin
            r = r - ANG_HALF;
        end
        angle_next = side.zero ? '0 : r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        angle_reg <= angle_next;
    end

    assign done  = done_reg;
    assign angle = $signed(angle_reg);

endmodule

[rtl/atan2_polynomial_fixed_point.sv]
// ----------------------------------------------------------------------------
// atan2_polynomial_fixed_point
// Four-quadrant fixed-point atan2 with a full turn of 65536.
// ----------------------------------------------------------------------------
// A new (y_value, x_value) beat is taken on every cycle that start is high;
// busy never rises, so one angle per clock is sustained. Each result shows
// on angle with done high for one cycle, after passing through one input
// stage, eight divider stages resolving two quotient bits each, ten stages
// for the five multiply and bias/shift steps of the polynomial, and one
// output fold stage. The receiver cannot stall, so results must be
// captured in the cycle done is high.
module atan2_polynomial_fixed_point
    import at2_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [DATA_W-1:0] y_value,
    input  logic signed [DATA_W-1:0] x_value,
    output logic                     done,
    output logic signed [DATA_W-1:0] angle
);

    logic                     prep_valid;
    logic [DATA_W-1:0]        prep_min;
    logic [DATA_W-1:0]        prep_max;
    at2_side_t                prep_side;

    logic                     div_valid;
    logic [Q_W-1:0]           div_q;
    at2_side_t                div_side;

    logic                     poly_valid;
    logic [Q_W-1:0]           poly_q;
    at2_side_t                poly_side;
    logic signed [DATA_W-1:0] poly_octant;

    // fully pipelined, every beat is taken
    assign busy = 1'b0;

    at2_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start & ~busy),
        .y_value   (y_value),
        .x_value   (x_value),
        .out_valid (prep_valid),
        .min_mag   (prep_min),
        .max_mag   (prep_max),
        .side      (prep_side)
    );

    at2_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_valid),
        .min_mag   (prep_min),
        .max_mag   (prep_max),
        .in_side   (prep_side),
        .out_valid (div_valid),
        .q         (div_q),
        .out_side  (div_side)
    );

    at2_poly u_poly (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid),
        .in_q      (div_q),
        .in_side   (div_side),
        .out_valid (poly_valid),
        .out_q     (poly_q),
        .out_side  (poly_side),
        .octant    (poly_octant)
    );

    at2_fold u_fold (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (poly_valid),
        .q        (poly_q),
        .side     (poly_side),
        .octant   (poly_octant),
        .done     (done),
        .angle    (angle)
    );

`ifndef NO_ASSERTIONS
    a_done_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("done without a matching start");

    a_start_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted beat produced no result");

    a_origin_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (start && y_value == '0 && x_value == '0) |-> ##LATENCY (angle == '0))
        else $error("origin did not give angle zero");

    a_neg_axis: assert property (@(posedge clk) disable iff (!rst_n)
        (start && y_value == '0 && x_value[DATA_W-1])
        |-> ##LATENCY (angle == $signed(ANG_HALF)))
        else $error("negative x axis did not give half turn");
`endif

endmodule
